// ----- rtl/kmme_pkg.sv -----
package kmme_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_FULL_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS     = 3'd0,
    REG_EMPTY_CODE      = 3'd1,
    REG_OCTAVE_UP_CODE  = 3'd2,
    REG_OCTAVE_DOWN_CODE = 3'd3,
    REG_SUSTAIN_CODE    = 3'd4,
    REG_PANIC_CODE      = 3'd5,
    REG_PRESS_VELOCITY  = 3'd6
  } cfg_reg_e;

  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_CC       = 8'hB0;
  localparam logic [3:0] CH_NOTES    = 4'd1;
  localparam logic [3:0] CH_CC       = 4'd2;
  localparam logic [3:0] CH_DRUMS    = 4'd10;
  localparam logic [6:0] DRUM_LOW    = 7'd35;
  localparam logic [6:0] DRUM_HIGH   = 7'd81;
  localparam logic signed [2:0] OCT_MAX = 3'sd3;
  localparam logic signed [2:0] OCT_MIN = -3'sd3;
  localparam logic signed [8:0] SEMITONES = 9'sd12;
  localparam logic signed [8:0] NOTE_MAX  = 9'sd127;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [6:0]  EMPTY_RST    = 7'd0;
  localparam logic [6:0]  OCT_UP_RST   = 7'd1;
  localparam logic [6:0]  OCT_DOWN_RST = 7'd2;
  localparam logic [6:0]  SUSTAIN_RST  = 7'd64;
  localparam logic [6:0]  PANIC_RST    = 7'd3;
  localparam logic [6:0]  VELOCITY_RST = 7'd100;

  typedef struct packed {
    logic [2:0]  row;
    logic [3:0]  column;
    logic        level;
    logic        reread;
    logic [31:0] now_ms;
    logic [6:0]  key_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } out_word_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [6:0]  empty_code;
    logic [6:0]  octave_up_code;
    logic [6:0]  octave_down_code;
    logic [6:0]  sustain_code;
    logic [6:0]  panic_code;
    logic [6:0]  press_velocity;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic oct_inc;
    logic oct_dec;
  } map_ctl_t;

endpackage

// ----- rtl/kmme_ram.sv -----
module kmme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 70,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/kmme_map.sv -----
module kmme_map (
  input  logic                signed [2:0] octave,
  input  logic [6:0]          code,
  input  logic                level,
  input  logic                kb_row,
  input  kmme_pkg::cfg_t      cfg,
  output kmme_pkg::map_ctl_t  ctl,
  output kmme_pkg::out_word_t msg
);

  logic signed [8:0] oct_ext;
  logic signed [8:0] note_sum;
  logic [6:0]        note;
  logic [7:0]        note_type;

  assign oct_ext   = {{6{octave[2]}}, octave};
  assign note_sum  = $signed({2'b00, code}) + oct_ext * kmme_pkg::SEMITONES;
  assign note_type = level ? kmme_pkg::ST_NOTE_ON : kmme_pkg::ST_NOTE_OFF;

  always_comb begin
    priority if (note_sum < 9'sd0) begin
      note = 7'd0;
    end else if (note_sum > kmme_pkg::NOTE_MAX) begin
      note = kmme_pkg::NOTE_MAX[6:0];
    end else begin
      note = note_sum[6:0];
    end
  end

  always_comb begin
    ctl = '0;
    msg.data_one = code;
    msg.data_two = level ? cfg.press_velocity : 7'd0;
    msg.status_byte = kmme_pkg::ST_CC | {4'd0, kmme_pkg::CH_CC - 4'd1};
    priority if (code == cfg.empty_code) begin
      ctl.emit = 1'b0;
    end else if (kb_row) begin
      ctl.emit = 1'b1;
      msg.data_one = note;
      msg.status_byte = note_type | {4'd0, kmme_pkg::CH_NOTES - 4'd1};
    end else if (code == cfg.octave_up_code && level) begin
      ctl.oct_inc = 1'b1;
    end else if (code == cfg.octave_down_code && level) begin
      ctl.oct_dec = 1'b1;
    end else if (code == cfg.sustain_code || code == cfg.panic_code) begin
      ctl.emit = 1'b1;
    end else if (code >= kmme_pkg::DRUM_LOW && code <= kmme_pkg::DRUM_HIGH) begin
      ctl.emit = 1'b1;
      msg.status_byte = note_type | {4'd0, kmme_pkg::CH_DRUMS - 4'd1};
    end else begin
      ctl.emit = 1'b1;
    end
  end

endmodule

// ----- rtl/key_matrix_midi_event.sv -----
// an accepted word is registered in the sample stage, and its message is then registered in
// the output register that drives out_data
// throughput: one word per cycle; input stalls only while a mapped change waits on a full
// output register; per-key state sits in a ram with registered read, with a one-entry
// bypass for back-to-back samples of the same key
// reset (rst_n low, synchronous): configuration registers to their defaults, key entries read as
// released at time zero until first written, octave shift zero, no word pending
module key_matrix_midi_event #(
  parameter int unsigned ROWS = 5,
  parameter int unsigned COLUMNS = 14,
  parameter int unsigned KEYBOARD_FIRST_ROW = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kmme_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kmme_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kmme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmme_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned KEYS = ROWS * COLUMNS;
  localparam int unsigned KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned IW = kmme_pkg::IDX_FULL_W;

  kmme_pkg::cfg_t      cfg_r;
  kmme_pkg::in_word_t  s1_word_r;
  logic                s1_valid_r;
  logic                fwd_r;
  logic [32:0]         fwd_entry_r;
  logic [KEYS-1:0]     time_valid_r;
  logic signed [2:0]   octave_r;
  kmme_pkg::out_word_t out_word_r;
  logic                out_valid_r;

  logic [IW-1:0]       in_idx_full;
  logic [IW-1:0]       s1_idx_full;
  logic [KEY_W-1:0]    in_idx;
  logic [KEY_W-1:0]    s1_idx;
  logic                in_accept;
  logic                s1_in_range;
  logic                s1_kb_row;
  logic [32:0]         ram_rdata;
  logic [32:0]         s1_entry;
  logic [32:0]         wr_entry;
  logic [31:0]         s1_time;
  logic                s1_down;
  logic [31:0]         s1_elapsed;
  logic                s1_change;
  logic                s1_emit;
  logic                s1_adv;
  logic                out_free;
  logic                wr_en;
  kmme_pkg::map_ctl_t  map_ctl;
  kmme_pkg::out_word_t map_msg;

  assign in_idx_full = IW'(in_data.row) * IW'(COLUMNS) + IW'(in_data.column);
  assign s1_idx_full = IW'(s1_word_r.row) * IW'(COLUMNS) + IW'(s1_word_r.column);
  assign in_idx = in_idx_full[KEY_W-1:0];
  assign s1_idx = s1_idx_full[KEY_W-1:0];

  assign s1_in_range = ({1'b0, s1_word_r.row} < 4'(ROWS))
                    && ({1'b0, s1_word_r.column} < 5'(COLUMNS));
  assign s1_kb_row = ({1'b0, s1_word_r.row} >= 4'(KEYBOARD_FIRST_ROW));

  // key entry: pressed bit above the last change time
  always_comb begin
    priority if (fwd_r) begin
      s1_entry = fwd_entry_r;
    end else if (s1_in_range && time_valid_r[s1_idx]) begin
      s1_entry = ram_rdata;
    end else begin
      s1_entry = 33'd0;
    end
  end

  assign s1_time  = s1_entry[31:0];
  assign s1_down  = s1_entry[32];
  assign wr_entry = {s1_word_r.level, s1_word_r.now_ms};

  assign s1_elapsed = s1_word_r.now_ms - s1_time;

  always_comb begin
    s1_change = 1'b0;
    if (s1_valid_r && s1_in_range) begin
      s1_change = (s1_word_r.level != s1_down)
               && (s1_word_r.reread == s1_word_r.level)
               && (s1_elapsed >= {16'd0, cfg_r.debounce_ms});
    end
  end

  kmme_map u_map (
    .octave (octave_r),
    .code   (s1_word_r.key_code),
    .level  (s1_word_r.level),
    .kb_row (s1_kb_row),
    .cfg    (cfg_r),
    .ctl    (map_ctl),
    .msg    (map_msg)
  );

  assign s1_emit   = s1_change && map_ctl.emit;
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!s1_emit || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign wr_en     = s1_adv && s1_change;

  kmme_ram #(
    .WIDTH (33),
    .DEPTH (KEYS)
  ) u_time_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (wr_entry),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
      fwd_r <= wr_en && (in_idx == s1_idx);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_data;
      fwd_entry_r <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_valid_r <= '0;
    end else if (wr_en) begin
      time_valid_r[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r <= 3'sd0;
    end else if (wr_en && map_ctl.oct_inc && octave_r != kmme_pkg::OCT_MAX) begin
      octave_r <= octave_r + 3'sd1;
    end else if (wr_en && map_ctl.oct_dec && octave_r != kmme_pkg::OCT_MIN) begin
      octave_r <= octave_r - 3'sd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_word_r <= map_msg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= kmme_pkg::DEBOUNCE_RST;
      cfg_r.empty_code <= kmme_pkg::EMPTY_RST;
      cfg_r.octave_up_code <= kmme_pkg::OCT_UP_RST;
      cfg_r.octave_down_code <= kmme_pkg::OCT_DOWN_RST;
      cfg_r.sustain_code <= kmme_pkg::SUSTAIN_RST;
      cfg_r.panic_code <= kmme_pkg::PANIC_RST;
      cfg_r.press_velocity <= kmme_pkg::VELOCITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kmme_pkg::REG_DEBOUNCE_MS:      cfg_r.debounce_ms <= cfg_data;
        kmme_pkg::REG_EMPTY_CODE:       cfg_r.empty_code <= cfg_data[6:0];
        kmme_pkg::REG_OCTAVE_UP_CODE:   cfg_r.octave_up_code <= cfg_data[6:0];
        kmme_pkg::REG_OCTAVE_DOWN_CODE: cfg_r.octave_down_code <= cfg_data[6:0];
        kmme_pkg::REG_SUSTAIN_CODE:     cfg_r.sustain_code <= cfg_data[6:0];
        kmme_pkg::REG_PANIC_CODE:       cfg_r.panic_code <= cfg_data[6:0];
        kmme_pkg::REG_PRESS_VELOCITY:   cfg_r.press_velocity <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
    octave_r != 3'sb100)
    else $error("octave shift out of range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_ready)
    else $error("input taken while sample stage stalled");

  a_time_marked: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> time_valid_r[$past(s1_idx)])
    else $error("key time not marked after update");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_emit))
    else $error("result word without a mapped change");

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && wr_en && in_idx == s1_idx) |=> fwd_r)
    else $error("bypass missed a same-key update");

endmodule
